@@ hw/rtl/image_upscale_2x_unit_macros.svh @@
// ----------------------------------------------------------------------------
// image_upscale_2x_unit_macros
// Assertion macros shared by the upscaler RTL. All of them sample on clk and
// are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef IMAGE_UPSCALE_2X_UNIT_MACROS_SVH
`define IMAGE_UPSCALE_2X_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hw/rtl/ius_pkg.sv @@
// ----------------------------------------------------------------------------
// ius_pkg
// Types, codes and weight tables of the 2x image upscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ius_pkg;

  // Default source image side length.
  localparam int SIDE_DEF = 256;

  // Interpolation mode codes.
  localparam logic [1:0] MODE_NEAREST  = 2'd0;
  localparam logic [1:0] MODE_BILINEAR = 2'd1;
  localparam logic [1:0] MODE_BICUBIC  = 2'd2;

  // Word kinds on the input channel.
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Fraction phases of an output coordinate: -1/4, 1/4 and 3/4.
  localparam logic [1:0] PH_NEG = 2'd0;
  localparam logic [1:0] PH_Q1  = 2'd1;
  localparam logic [1:0] PH_Q3  = 2'd2;

  // Weights are scaled by 128 per axis, so a 2-D weight is scaled by 2^14.
  localparam int FRAC_SHIFT = 14;
  localparam int WGT_W      = 17;
  localparam int PROD_W     = 26;
  localparam int ACC_W      = 26;
  localparam logic signed [WGT_W-1:0] WGT_ONE = 17'sd16384;
  localparam logic signed [ACC_W-1:0] ACC_MAX = 26'sd4177920;
  localparam logic [7:0] PIX_MAX = 8'd255;
  localparam logic [7:0] PIX_MIN = 8'd0;

  // Catmull-Rom taps, indexed by phase then neighbour.
  localparam logic signed [8:0] CUBIC_W [3][4] = '{
    '{ 9'sd25,  9'sd105, 9'sd3,   -9'sd5 },
    '{ -9'sd9,  9'sd111, 9'sd29,  -9'sd3 },
    '{ -9'sd3,  9'sd29,  9'sd111, -9'sd9 }
  };

  // Linear taps, indexed by phase then neighbour.
  localparam logic signed [8:0] LIN_W [3][2] = '{
    '{ 9'sd160, -9'sd32 },
    '{ 9'sd96,  9'sd32  },
    '{ 9'sd32,  9'sd96  }
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/ius_in_if.sv @@
// ----------------------------------------------------------------------------
// ius_in_if
// Input channel of the upscaler: store and query words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ius_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] src_row;
  logic [7:0] src_col;
  logic [7:0] src_value;
  logic [8:0] dst_row;
  logic [8:0] dst_col;

  modport source (
    output valid, kind, src_row, src_col, src_value, dst_row, dst_col,
    input  ready
  );

  modport sink (
    input  valid, kind, src_row, src_col, src_value, dst_row, dst_col,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/ius_out_if.sv @@
// ----------------------------------------------------------------------------
// ius_out_if
// Result channel of the upscaler: one interpolated pixel per query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ius_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] upscaled_pixel;
  logic       clipped;

  modport source (
    output valid, upscaled_pixel, clipped,
    input  ready
  );

  modport sink (
    input  valid, upscaled_pixel, clipped,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/image_upscale_2x_unit.sv @@
// ----------------------------------------------------------------------------
// image_upscale_2x_unit
// 2x image upscaler (nearest, bilinear or Catmull-Rom bicubic) over a
// source image held in one single-port synchronous memory.
// ----------------------------------------------------------------------------
//   Channel    Side    Carries
//   in_item    sink    kind, src_row, src_col, src_value, dst_row, dst_col
//   result     source  upscaled_pixel, clipped
//   cfg_we     input   write strobe of mode (cfg_wdata)
//
// A store word writes the memory at acceptance if src_row and src_col lie inside the image.
// A query is accepted, then issues 1, 4 or 16 tap reads (nearest, bilinear,
// bicubic), which pass through the read, multiply and accumulate stages before
// the result register is loaded. A new word is taken while the result waits;
// a query stalls at its end only while the previous one waits.
// Reset sets bicubic mode and leaves the image memory unwritten.
`timescale 1ns / 1ps
`default_nettype none

module image_upscale_2x_unit #(
  parameter int SIDE = ius_pkg::SIDE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  ius_in_if.sink          in_item,
  ius_out_if.source       result
);

`include "image_upscale_2x_unit_macros.svh"

  localparam int SW   = $clog2(SIDE);
  localparam int DW   = SW + 1;
  localparam int AW   = $clog2(SIDE * SIDE);
  localparam int DLIM = 2 * SIDE - 1;

  ius_pkg::state_t state, state_next;

  logic [1:0]    mode;
  logic [3:0]    tap;
  logic [3:0]    last_tap;
  logic          is_near;
  logic          is_lin;
  logic [SW-1:0] by, bx, near_r, near_c;
  logic [1:0]    py, px;

  logic          in_ready;
  logic          tap_issue;
  logic          out_load;
  logic          store_acc;
  logic          query_acc;
  logic          store_ok;

  logic [DW-1:0] dr, dc;
  logic [SW-1:0] by_new, bx_new;
  logic [1:0]    py_new, px_new;

  logic signed [2:0]    off_r, off_c;
  logic signed [SW+1:0] rs, cs;
  logic [SW-1:0]        row_sel, col_sel;
  logic signed [8:0]    wy, wx;
  logic signed [17:0]   wprod;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;

  logic [7:0] mem [SIDE*SIDE];
  logic [7:0] rdata;

  logic                       rd_vld, rd_last;
  logic signed [ius_pkg::WGT_W-1:0]  w_q;
  logic                       prod_vld, prod_last;
  logic signed [ius_pkg::PROD_W-1:0] prod;
  logic signed [ius_pkg::ACC_W-1:0]  acc;
  logic                       acc_done;

  logic       out_valid;
  logic [7:0] out_pixel;
  logic       out_clip;

  function automatic logic [SW-1:0] clamp_idx(input logic signed [SW+1:0] v);
    logic [SW-1:0] r;
    if (v[SW+1]) begin
      r = '0;
    end else if (v > $signed((SW+2)'(SIDE - 1))) begin
      r = SW'(SIDE - 1);
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  function automatic logic [SW:0] split_base(input logic [DW-1:0] d);
    // Returns {phase is odd, base}; the caller decodes the phase separately.
    logic [SW:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d[0]) begin
      r = {1'b1, SW'(d >> 1)};
    end else begin
      r = {1'b0, SW'((d - DW'(1)) >> 1)};
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Acceptance and coordinate split
  // --------------------------------------------------------------------------
  assign store_acc = in_item.valid && in_ready && (in_item.kind == ius_pkg::KIND_STORE);
  assign query_acc = in_item.valid && in_ready && (in_item.kind == ius_pkg::KIND_QUERY);
  assign store_ok  = (32'(in_item.src_row) < SIDE) && (32'(in_item.src_col) < SIDE);

  assign dr = (32'(in_item.dst_row) > DLIM) ? DW'(DLIM) : DW'(in_item.dst_row);
  assign dc = (32'(in_item.dst_col) > DLIM) ? DW'(DLIM) : DW'(in_item.dst_col);

  always_comb begin
    logic [SW:0] sr, sc;
    sr = split_base(dr);
    sc = split_base(dc);
    by_new = sr[SW-1:0];
    bx_new = sc[SW-1:0];
    if (dr == '0) begin
      py_new = ius_pkg::PH_NEG;
    end else if (sr[SW]) begin
      py_new = ius_pkg::PH_Q1;
    end else begin
      py_new = ius_pkg::PH_Q3;
    end
    if (dc == '0) begin
      px_new = ius_pkg::PH_NEG;
    end else if (sc[SW]) begin
      px_new = ius_pkg::PH_Q1;
    end else begin
      px_new = ius_pkg::PH_Q3;
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      by     <= by_new;
      bx     <= bx_new;
      py     <= py_new;
      px     <= px_new;
      near_r <= SW'(dr >> 1);
      near_c <= SW'(dc >> 1);
    end
  end

  assign is_near  = (mode == ius_pkg::MODE_NEAREST);
  assign is_lin   = (mode == ius_pkg::MODE_BILINEAR);
  assign last_tap = is_near ? 4'd0 : (is_lin ? 4'd3 : 4'd15);

  // --------------------------------------------------------------------------
  // Tap address and weight
  // --------------------------------------------------------------------------
  always_comb begin
    if (is_lin) begin
      off_r = $signed({2'b00, tap[1]});
      off_c = $signed({2'b00, tap[0]});
      wy    = ius_pkg::LIN_W[py][tap[1]];
      wx    = ius_pkg::LIN_W[px][tap[0]];
    end else begin
      // Bicubic taps run from one before the base to two after it.
      off_r = $signed({1'b0, tap[3:2]}) - 3'sd1;
      off_c = $signed({1'b0, tap[1:0]}) - 3'sd1;
      wy    = ius_pkg::CUBIC_W[py][tap[3:2]];
      wx    = ius_pkg::CUBIC_W[px][tap[1:0]];
    end
    rs    = $signed({2'b00, by}) + (SW+2)'(off_r);
    cs    = $signed({2'b00, bx}) + (SW+2)'(off_c);
    wprod = wy * wx;
    if (is_near) begin
      row_sel = near_r;
      col_sel = near_c;
    end else begin
      row_sel = clamp_idx(rs);
      col_sel = clamp_idx(cs);
    end
  end

  assign mem_we   = store_acc && store_ok;
  assign mem_addr = mem_we ? AW'(SW'(in_item.src_row) * SIDE + SW'(in_item.src_col))
                           : AW'(row_sel * SIDE + col_sel);

  // Single-port image memory, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_item.src_value;
    end
    rdata <= mem[mem_addr];
  end

  // --------------------------------------------------------------------------
  // Weight, multiply and accumulate stages
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    w_q       <= is_near ? ius_pkg::WGT_ONE : ius_pkg::WGT_W'(wprod);
    rd_last   <= (tap == last_tap);
    prod      <= w_q * $signed({1'b0, rdata});
    prod_last <= rd_last;
    if (query_acc) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      rd_vld   <= tap_issue;
      prod_vld <= rd_vld;
      acc_done <= prod_vld && prod_last;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ius_pkg::ST_IDLE: begin
        if (query_acc) begin
          state_next = ius_pkg::ST_TAPS;
        end
      end
      ius_pkg::ST_TAPS: begin
        if (tap == last_tap) begin
          state_next = ius_pkg::ST_DRAIN;
        end
      end
      ius_pkg::ST_DRAIN: begin
        if (acc_done) begin
          state_next = ius_pkg::ST_RESULT;
        end
      end
      ius_pkg::ST_RESULT: begin
        if (out_load) begin
          state_next = ius_pkg::ST_IDLE;
        end
      end
      default: state_next = ius_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    tap_issue = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ius_pkg::ST_IDLE:   in_ready  = 1'b1;
      ius_pkg::ST_TAPS:   tap_issue = 1'b1;
      ius_pkg::ST_DRAIN:  ;
      ius_pkg::ST_RESULT: out_load  = !out_valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ius_pkg::ST_IDLE;
      tap   <= '0;
      mode  <= ius_pkg::MODE_BICUBIC;
    end else begin
      state <= state_next;
      if (query_acc) begin
        tap <= '0;
      end else if (tap_issue) begin
        tap <= tap + 4'd1;
      end
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (out_load) begin
      // The sum is over 2^14; negative or oversized sums saturate and clip.
      if (acc[ius_pkg::ACC_W-1]) begin
        out_pixel <= ius_pkg::PIX_MIN;
        out_clip  <= 1'b1;
      end else if (acc > ius_pkg::ACC_MAX) begin
        out_pixel <= ius_pkg::PIX_MAX;
        out_clip  <= 1'b1;
      end else begin
        out_pixel <= acc[ius_pkg::FRAC_SHIFT+7:ius_pkg::FRAC_SHIFT];
        out_clip  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_item.ready         = in_ready;
  assign result.valid          = out_valid;
  assign result.upscaled_pixel = out_pixel;
  assign result.clipped        = out_clip;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_no_overwrite, out_valid && !result.ready, !out_load, "result overwritten")
  `ASSERT_IMPLIES(a_done_in_drain, acc_done, state == ius_pkg::ST_DRAIN, "late accumulate")
  `ASSERT_IMPLIES(a_tap_bound, state == ius_pkg::ST_TAPS, tap <= last_tap, "tap past last")
  `ASSERT_NEXT(a_query_starts, query_acc, state == ius_pkg::ST_TAPS, "query did not start")
  `ASSERT_IMPLIES(a_pipe_quiet, state == ius_pkg::ST_IDLE, !rd_vld && !prod_vld, "stage busy")

endmodule

`default_nettype wire

@@ test/upscale_checker.sv @@
// ----------------------------------------------------------------------------
// upscale_checker
// Watches both channels and the mode register of the 2x upscaler. It keeps
// its own copy of the source image, works out each queried output pixel,
// and compares every result word with the oldest expected pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upscale_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  ius_in_if               in_mon,
  ius_out_if              out_mon,
  output int              fail_count,
  output int              pending
);
  import ius_pkg::*;

  localparam int SIDE = SIDE_DEF;
  localparam int DEN  = 16384;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [7:0] pixel;
    logic       clip;
  } upscaled_t;

  logic [7:0] src_image [0:SIDE*SIDE-1];
  logic [1:0] interp_mode;
  upscaled_t  expected_pixels [$];
  int         errors = 0;

  assign fail_count = errors;

  task automatic report(input string msg);
    errors++;
    if (errors <= REPORT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Catmull-Rom taps scaled by 128.
  function automatic int cubic_tap(input logic [1:0] ph, input logic [1:0] k);
    case ({ph, k})
      {PH_NEG, 2'd0}: return 25;
      {PH_NEG, 2'd1}: return 105;
      {PH_NEG, 2'd2}: return 3;
      {PH_NEG, 2'd3}: return -5;
      {PH_Q1, 2'd0}:  return -9;
      {PH_Q1, 2'd1}:  return 111;
      {PH_Q1, 2'd2}:  return 29;
      {PH_Q1, 2'd3}:  return -3;
      {PH_Q3, 2'd0}:  return -3;
      {PH_Q3, 2'd1}:  return 29;
      {PH_Q3, 2'd2}:  return 111;
      default:        return -9;
    endcase
  endfunction

  function automatic int linear_tap(input logic [1:0] ph, input logic k);
    case ({ph, k})
      {PH_NEG, 1'b0}: return 160;
      {PH_NEG, 1'b1}: return -32;
      {PH_Q1, 1'b0}:  return 96;
      {PH_Q1, 1'b1}:  return 32;
      {PH_Q3, 1'b0}:  return 32;
      default:        return 96;
    endcase
  endfunction

  // The source position is d/2 - 1/4 with its integer part truncated toward
  // zero, which leaves only three possible fractions.
  function automatic void split_coord(input int d, output int base, output logic [1:0] ph);
    if (d == 0) begin
      base = 0;
      ph   = PH_NEG;
    end else if (d % 2 == 1) begin
      base = d / 2;
      ph   = PH_Q1;
    end else begin
      base = (d - 1) / 2;
      ph   = PH_Q3;
    end
  endfunction

  function automatic int clamp_index(input int v);
    if (v < 0) return 0;
    else if (v > SIDE - 1) return SIDE - 1;
    else return v;
  endfunction

  function automatic int pixel_at(input int r, input int c);
    return int'(src_image[clamp_index(r) * SIDE + clamp_index(c)]);
  endfunction

  function automatic upscaled_t interpolate_pixel(input logic [1:0] mode,
                                                  input int dr, input int dc);
    upscaled_t   res;
    int          by, bx;
    logic [1:0]  py, px;
    longint      acc;
    longint      q;
    acc = 0;
    if (mode == MODE_NEAREST) begin
      res.pixel = 8'(pixel_at(dr / 2, dc / 2));
      res.clip  = 1'b0;
    end else begin
      split_coord(dr, by, py);
      split_coord(dc, bx, px);
      if (mode == MODE_BILINEAR) begin
        for (int i = 0; i < 2; i++)
          for (int j = 0; j < 2; j++)
            acc += longint'(linear_tap(py, i[0]) * linear_tap(px, j[0]) *
                            pixel_at(by + i, bx + j));
      end else begin
        // The unused mode code falls through to bicubic as well.
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++)
            acc += longint'(cubic_tap(py, i[1:0]) * cubic_tap(px, j[1:0]) *
                            pixel_at(by - 1 + i, bx - 1 + j));
      end
      q = acc / DEN;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      res.pixel = q[7:0];
      res.clip  = (acc < 0) || (acc > longint'(255) * DEN);
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    upscaled_t want;
    if (rst) begin
      interp_mode = MODE_BICUBIC;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        interp_mode = cfg_wdata;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          report($sformatf("result word pixel=%0d clipped=%0b with no query waiting",
                           out_mon.upscaled_pixel, out_mon.clipped));
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.upscaled_pixel !== want.pixel) begin
            report($sformatf("upscaled_pixel got %0d expected %0d",
                             out_mon.upscaled_pixel, want.pixel));
          end
          if (out_mon.clipped !== want.clip) begin
            report($sformatf("clipped got %0b expected %0b (pixel %0d)",
                             out_mon.clipped, want.clip, want.pixel));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_STORE) begin
          src_image[{in_mon.src_row, in_mon.src_col}] = in_mon.src_value;
        end else begin
          expected_pixels.push_back(interpolate_pixel(interp_mode,
                                                      int'(in_mon.dst_row),
                                                      int'(in_mon.dst_col)));
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the 2x upscaler test. It drives store and query words through all
// four mode codes under several idle and stall patterns, making sure every
// pixel that a query reads has been written first, and gives the verdict
// from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ius_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WORDS_PER_PHASE = 215;
  localparam int NUM_PHASES      = 8;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PIX_LAST        = SIDE_DEF - 1;
  localparam int DST_LAST        = 2 * SIDE_DEF - 1;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  int         words_sent  = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         last_dr = 0;
  int         last_dc = 0;
  bit         written [0:SIDE_DEF*SIDE_DEF-1];

  ius_in_if  in_bus ();
  ius_out_if out_bus ();

  image_upscale_2x_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_bus),
    .result    (out_bus)
  );

  upscale_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] clamp_src(input int v);
    if (v < 0) return 8'd0;
    else if (v > PIX_LAST) return PIX_LAST[7:0];
    else return v[7:0];
  endfunction

  function automatic int clamp_dst(input int v);
    if (v < 0) return 0;
    else if (v > DST_LAST) return DST_LAST;
    else return v;
  endfunction

  // First row or column of the 4x4 bicubic window; it covers the taps of
  // the nearest and bilinear modes as well.
  function automatic int tap_origin(input int d);
    if (d == 0) return -1;
    else if (d % 2 == 1) return d / 2 - 1;
    else return (d - 1) / 2 - 1;
  endfunction

  function automatic int border_coord();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return DST_LAST - 2;
      4:       return DST_LAST - 1;
      default: return DST_LAST;
    endcase
  endfunction

  // Extremes are favored so that bicubic overshoot and undershoot occur.
  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1:    return 8'd0;
      2, 3:    return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input logic k, input logic [7:0] sr, input logic [7:0] sc,
                           input logic [7:0] sv, input logic [8:0] dr,
                           input logic [8:0] dc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= k;
    in_bus.src_row   <= sr;
    in_bus.src_col   <= sc;
    in_bus.src_value <= sv;
    in_bus.dst_row   <= dr;
    in_bus.dst_col   <= dc;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic store_pixel(input logic [7:0] r, input logic [7:0] c, input logic [7:0] v);
    send_word(KIND_STORE, r, c, v, 9'($urandom_range(0, DST_LAST)),
              9'($urandom_range(0, DST_LAST)));
    written[{r, c}] = 1'b1;
  endtask

  // Any pixel of the window not yet written gets a store word first.
  task automatic query_pixel(input int dr, input int dc);
    logic [7:0] r, c;
    int         r0, c0;
    r0 = tap_origin(dr);
    c0 = tap_origin(dc);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        r = clamp_src(r0 + i);
        c = clamp_src(c0 + j);
        if (!written[{r, c}]) store_pixel(r, c, pick_value());
      end
    end
    send_word(KIND_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), dr[8:0], dc[8:0]);
    last_dr = dr;
    last_dc = dc;
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_interp_mode(input logic [1:0] mode);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [1:0] phase_mode(input int p);
    case (p)
      0:       return MODE_NEAREST;
      1:       return MODE_BILINEAR;
      2:       return MODE_BICUBIC;
      3:       return MODE_UNUSED;
      4:       return MODE_BILINEAR;
      5:       return MODE_NEAREST;
      6:       return MODE_UNUSED;
      default: return MODE_BICUBIC;
    endcase
  endfunction

  task automatic random_word();
    int roll;
    int dr, dc;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      // Disturb the window of the last query.
      store_pixel(clamp_src(tap_origin(last_dr) + $urandom_range(0, 3)),
                  clamp_src(tap_origin(last_dc) + $urandom_range(0, 3)), pick_value());
    end else if (roll < 20) begin
      store_pixel(8'($urandom_range(0, PIX_LAST)), 8'($urandom_range(0, PIX_LAST)),
                  8'($urandom_range(0, 255)));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        dr = clamp_dst(last_dr + $urandom_range(0, 8) - 4);
        dc = clamp_dst(last_dc + $urandom_range(0, 8) - 4);
      end else if (roll < 75) begin
        dr = border_coord();
        dc = ($urandom_range(0, 1) == 0) ? border_coord() : $urandom_range(0, DST_LAST);
      end else begin
        dr = $urandom_range(0, DST_LAST);
        dc = $urandom_range(0, DST_LAST);
      end
      query_pixel(dr, dc);
    end
  endtask

  initial begin
    int phase_end;
    int hold_at;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= MODE_BICUBIC;
    in_bus.valid     <= 1'b0;
    in_bus.kind      <= KIND_STORE;
    in_bus.src_row   <= 8'd0;
    in_bus.src_col   <= 8'd0;
    in_bus.src_value <= 8'd0;
    in_bus.dst_row   <= 9'd0;
    in_bus.dst_col   <= 9'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words run in the reset mode, bicubic. A bright 2x2 core with
    // a dark ring overshoots at output (21,21).
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        store_pixel(8'(9 + i), 8'(9 + j),
                    (i == 0 || i == 3 || j == 0 || j == 3) ? 8'd0 : 8'd255);
    query_pixel(21, 21);
    // Dark core with a bright top edge pulls the sum below zero.
    for (int i = 1; i < 3; i++)
      for (int j = 1; j < 3; j++)
        store_pixel(8'(9 + i), 8'(9 + j), 8'd0);
    store_pixel(8'd9, 8'd10, 8'd255);
    store_pixel(8'd9, 8'd11, 8'd255);
    query_pixel(21, 21);
    // Corners exercise border clamping and the extrapolating fraction.
    query_pixel(0, 0);
    query_pixel(DST_LAST, DST_LAST);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_interp_mode(phase_mode(p));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      phase_end = words_sent + WORDS_PER_PHASE;
      hold_at   = (p == 2) ? words_sent + WORDS_PER_PHASE / 2 : phase_end + 1;
      while (words_sent < phase_end) begin
        if (words_sent >= hold_at) begin
          // The sender holds off until every queued result has drained.
          wait_idle();
          hold_at = phase_end + 1;
        end
        random_word();
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
